FILE: rtl/core/gnl_pkg.sv
// Package for the grammar notation lexer: request structs, codes, phases.
// No dependencies.
package gnl_pkg;

	localparam int unsigned MAX_NEST_DEF = 255;
	localparam int unsigned LEN_BITS_DEF = 16;

	typedef enum logic [3:0] {
		MODE_ROOT = 4'b0001,
		MODE_RULE = 4'b0010,
		MODE_FUNC = 4'b0100,
		MODE_SPARE = 4'b1000
	} mode_t;

	typedef enum logic [9:0] {
		PH_IDLE = 10'b00_0000_0001,
		PH_HASH1 = 10'b00_0000_0010,
		PH_HASHID = 10'b00_0000_0100,
		PH_SLASH = 10'b00_0000_1000,
		PH_SQ = 10'b00_0001_0000,
		PH_DQ = 10'b00_0010_0000,
		PH_LINE = 10'b00_0100_0000,
		PH_BLOCK = 10'b00_1000_0000,
		PH_BSLASH = 10'b01_0000_0000,
		PH_BBRACE = 10'b10_0000_0000
	} phase_t;

	localparam logic [3:0] TK_HASHTAG = 4'd0;
	localparam logic [3:0] TK_SQSTR = 4'd1;
	localparam logic [3:0] TK_DQSTR = 4'd2;
	localparam logic [3:0] TK_COMMA = 4'd3;
	localparam logic [3:0] TK_SEMI = 4'd4;
	localparam logic [3:0] TK_BAR = 4'd5;
	localparam logic [3:0] TK_MINUS = 4'd6;
	localparam logic [3:0] TK_EQUALS = 4'd7;
	localparam logic [3:0] TK_PAREN = 4'd8;
	localparam logic [3:0] TK_CURLY = 4'd9;
	localparam logic [3:0] TK_SQUARE = 4'd10;
	localparam logic [3:0] TK_SPACE = 4'd11;
	localparam logic [3:0] TK_COMMENT = 4'd12;
	localparam logic [3:0] TK_CALLPAREN = 4'd13;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_BYTE = 3'd1;
	localparam logic [2:0] ERR_SQ = 3'd2;
	localparam logic [2:0] ERR_DQ = 3'd3;
	localparam logic [2:0] ERR_COMMENT = 3'd4;
	localparam logic [2:0] ERR_NEST = 3'd5;

	typedef struct packed {
		logic [7:0] source_byte;
		logic end_of_text;
	} in_req_t;

	typedef struct packed {
		logic [3:0] token_kind;
		logic [15:0] token_length;
		logic [2:0] error_code;
		logic last_of_run;
	} out_req_t;

	function automatic logic is_space(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d || b == 8'h0b
			|| b == 8'h0c;
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
	endfunction

	function automatic logic is_ident(input logic [7:0] b);
		return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == 8'h5f;
	endfunction

endpackage

FILE: rtl/core/gnl_step.sv
// Per-byte next-state and result logic of the grammar notation lexer.
// Depends on gnl_pkg.
module gnl_step #(
	parameter int unsigned MAX_NEST = gnl_pkg::MAX_NEST_DEF,
	parameter int unsigned LEN_BITS = gnl_pkg::LEN_BITS_DEF,
	localparam int unsigned DW = $clog2(MAX_NEST + 1)
) (
	input gnl_pkg::in_req_t req,
	input gnl_pkg::mode_t mode_q,
	input logic pend_q,
	input gnl_pkg::phase_t phase_q,
	input logic [DW-1:0] depth_q,
	input logic [LEN_BITS-1:0] len_q,
	input logic hold_q,
	output gnl_pkg::mode_t mode_d,
	output logic pend_d,
	output gnl_pkg::phase_t phase_d,
	output logic [DW-1:0] depth_d,
	output logic [LEN_BITS-1:0] len_d,
	output logic hold_d,
	output logic [1:0] n_out,
	output gnl_pkg::out_req_t res0,
	output gnl_pkg::out_req_t res1
);

	localparam int unsigned CW = (LEN_BITS > 16) ? 16 : LEN_BITS;
	localparam logic [LEN_BITS-1:0] CAP = LEN_BITS'({CW{1'b1}});
	localparam logic [DW-1:0] MAXD = DW'(MAX_NEST);

	gnl_pkg::out_req_t r [2];
	logic [7:0] b;
	logic eot;
	logic adj;
	logic do_start;
	logic [LEN_BITS-1:0] bumped;
	logic [1:0] n;
	gnl_pkg::mode_t m;

	function automatic gnl_pkg::out_req_t mk(input logic [3:0] k, input logic [15:0] l,
		input logic [2:0] e);
		gnl_pkg::out_req_t o;
		o.token_kind = k;
		o.token_length = l;
		o.error_code = e;
		o.last_of_run = 1'b0;
		return o;
	endfunction

	always_comb begin
		b = req.source_byte;
		eot = req.end_of_text;
		bumped = (len_q < CAP) ? len_q + 1'b1 : len_q;
		mode_d = mode_q;
		pend_d = pend_q;
		phase_d = phase_q;
		depth_d = depth_q;
		len_d = len_q;
		hold_d = hold_q;
		n = 2'd0;
		r[0] = mk(4'd0, 16'd0, gnl_pkg::ERR_NONE);
		r[1] = r[0];
		adj = 1'b0;
		do_start = 1'b0;
		m = mode_q;
		if (!hold_q) begin
			unique case (phase_q)
				gnl_pkg::PH_HASH1: begin
					if (gnl_pkg::is_alpha(b)) begin
						len_d = bumped;
						phase_d = gnl_pkg::PH_HASHID;
					end else begin
						r[0] = mk(4'd0, 16'd0, gnl_pkg::ERR_BYTE);
						n = 2'd1;
						hold_d = 1'b1;
					end
				end
				gnl_pkg::PH_HASHID: begin
					if (gnl_pkg::is_ident(b)) begin
						len_d = bumped;
					end else begin
						r[0] = mk(gnl_pkg::TK_HASHTAG, 16'(len_q), gnl_pkg::ERR_NONE);
						n = 2'd1;
						phase_d = gnl_pkg::PH_IDLE;
						len_d = '0;
						adj = 1'b1;
						do_start = 1'b1;
					end
				end
				gnl_pkg::PH_SLASH: begin
					if (b == 8'h2f) begin
						len_d = bumped;
						phase_d = gnl_pkg::PH_LINE;
					end else if (b == 8'h7b) begin
						len_d = bumped;
						depth_d = DW'(1);
						phase_d = gnl_pkg::PH_BLOCK;
					end else begin
						r[0] = mk(4'd0, 16'd0, gnl_pkg::ERR_BYTE);
						n = 2'd1;
						hold_d = 1'b1;
					end
				end
				gnl_pkg::PH_LINE: begin
					len_d = bumped;
					if (b == 8'h0a) begin
						r[0] = mk(gnl_pkg::TK_COMMENT, 16'(bumped), gnl_pkg::ERR_NONE);
						n = 2'd1;
						phase_d = gnl_pkg::PH_IDLE;
						len_d = '0;
					end
				end
				gnl_pkg::PH_SQ, gnl_pkg::PH_DQ: begin
					len_d = bumped;
					if (b == ((phase_q == gnl_pkg::PH_SQ) ? 8'h27 : 8'h22)) begin
						r[0] = mk((phase_q == gnl_pkg::PH_SQ) ? gnl_pkg::TK_SQSTR
							: gnl_pkg::TK_DQSTR, 16'(bumped), gnl_pkg::ERR_NONE);
						n = 2'd1;
						phase_d = gnl_pkg::PH_IDLE;
						len_d = '0;
					end
				end
				gnl_pkg::PH_BLOCK, gnl_pkg::PH_BSLASH, gnl_pkg::PH_BBRACE: begin
					len_d = bumped;
					if (phase_q == gnl_pkg::PH_BSLASH && b == 8'h7b) begin
						if (depth_q >= MAXD) begin
							r[0] = mk(4'd0, 16'd0, gnl_pkg::ERR_NEST);
							n = 2'd1;
							hold_d = 1'b1;
						end else begin
							depth_d = depth_q + 1'b1;
							phase_d = gnl_pkg::PH_BLOCK;
						end
					end else if (phase_q == gnl_pkg::PH_BBRACE && b == 8'h2f) begin
						if (depth_q <= DW'(1)) begin
							depth_d = '0;
							r[0] = mk(gnl_pkg::TK_COMMENT, 16'(bumped), gnl_pkg::ERR_NONE);
							n = 2'd1;
							phase_d = gnl_pkg::PH_IDLE;
							len_d = '0;
						end else begin
							depth_d = depth_q - 1'b1;
							phase_d = gnl_pkg::PH_BLOCK;
						end
					end else if (b == 8'h2f) begin
						phase_d = gnl_pkg::PH_BSLASH;
					end else if (b == 8'h7d) begin
						phase_d = gnl_pkg::PH_BBRACE;
					end else begin
						phase_d = gnl_pkg::PH_BLOCK;
					end
				end
				default: do_start = 1'b1;
			endcase

			// Start a new token from this byte.
			if (do_start) begin
				if (gnl_pkg::is_space(b) || b == 8'h2f) begin
					if (adj) pend_d = 1'b1;
				end else begin
					if (pend_q || adj) begin
						if (b == 8'h3d) m = gnl_pkg::MODE_RULE;
						else if (adj && b == 8'h28) m = gnl_pkg::MODE_FUNC;
					end
					pend_d = 1'b0;
				end
				mode_d = m;
				if (gnl_pkg::is_space(b)) begin
					r[n[0]] = mk(gnl_pkg::TK_SPACE, 16'd1, gnl_pkg::ERR_NONE);
					n = n + 1'b1;
					phase_d = gnl_pkg::PH_IDLE;
					len_d = '0;
				end else if (b == 8'h2f || b == 8'h23) begin
					phase_d = (b == 8'h2f) ? gnl_pkg::PH_SLASH : gnl_pkg::PH_HASH1;
					len_d = LEN_BITS'(1);
				end else if (m == gnl_pkg::MODE_RULE && (b == 8'h27 || b == 8'h22)) begin
					phase_d = (b == 8'h27) ? gnl_pkg::PH_SQ : gnl_pkg::PH_DQ;
					len_d = LEN_BITS'(1);
				end else begin
					logic [3:0] k;
					logic ok;
					ok = 1'b1;
					k = gnl_pkg::TK_SPACE;
					if (m == gnl_pkg::MODE_RULE) begin
						unique case (b)
							8'h2c: k = gnl_pkg::TK_COMMA;
							8'h3b: k = gnl_pkg::TK_SEMI;
							8'h7c: k = gnl_pkg::TK_BAR;
							8'h2d: k = gnl_pkg::TK_MINUS;
							8'h3d: k = gnl_pkg::TK_EQUALS;
							8'h28, 8'h29: k = gnl_pkg::TK_PAREN;
							8'h7b, 8'h7d: k = gnl_pkg::TK_CURLY;
							8'h5b, 8'h5d: k = gnl_pkg::TK_SQUARE;
							default: ok = 1'b0;
						endcase
						if (b == 8'h3b) mode_d = gnl_pkg::MODE_ROOT;
					end else if (m == gnl_pkg::MODE_FUNC && (b == 8'h28 || b == 8'h29)) begin
						k = gnl_pkg::TK_CALLPAREN;
					end else begin
						ok = 1'b0;
					end
					r[n[0]] = ok ? mk(k, 16'd1, gnl_pkg::ERR_NONE)
						: mk(4'd0, 16'd0, gnl_pkg::ERR_BYTE);
					n = n + 1'b1;
					phase_d = gnl_pkg::PH_IDLE;
					len_d = '0;
					if (!ok) hold_d = 1'b1;
				end
			end

			// End of text closes or faults whatever is still open.
			if (eot && !hold_d) begin
				unique case (phase_d)
					gnl_pkg::PH_HASH1, gnl_pkg::PH_SLASH: begin
						r[n[0]] = mk(4'd0, 16'd0, gnl_pkg::ERR_BYTE); n = n + 1'b1;
					end
					gnl_pkg::PH_HASHID: begin
						r[n[0]] = mk(gnl_pkg::TK_HASHTAG, 16'(len_d), gnl_pkg::ERR_NONE);
						n = n + 1'b1;
					end
					gnl_pkg::PH_LINE: begin
						r[n[0]] = mk(gnl_pkg::TK_COMMENT, 16'(len_d), gnl_pkg::ERR_NONE);
						n = n + 1'b1;
					end
					gnl_pkg::PH_SQ: begin
						r[n[0]] = mk(4'd0, 16'd0, gnl_pkg::ERR_SQ); n = n + 1'b1;
					end
					gnl_pkg::PH_DQ: begin
						r[n[0]] = mk(4'd0, 16'd0, gnl_pkg::ERR_DQ); n = n + 1'b1;
					end
					gnl_pkg::PH_BLOCK, gnl_pkg::PH_BSLASH, gnl_pkg::PH_BBRACE: begin
						r[n[0]] = mk(4'd0, 16'd0, gnl_pkg::ERR_COMMENT); n = n + 1'b1;
					end
					default: ;
				endcase
			end
		end
		if (eot) begin
			mode_d = gnl_pkg::MODE_ROOT;
			pend_d = 1'b0;
			phase_d = gnl_pkg::PH_IDLE;
			depth_d = '0;
			len_d = '0;
			hold_d = 1'b0;
		end
		if (n == 2'd1) r[0].last_of_run = 1'b1;
		if (n == 2'd2) r[1].last_of_run = 1'b1;
		n_out = n;
		res0 = r[0];
		res1 = r[1];
	end

endmodule

FILE: rtl/core/grammar_notation_lexer_top.sv
// Top level of the grammar notation lexer: state registers and output queue.
// Depends on gnl_pkg and gnl_step.
//
// Usage: one source byte enters per request on the input channel
// (in_valid / in_stall, payload in_data with source_byte and end_of_text).
// Each byte yields zero, one or two result requests on the output channel
// (out_valid / out_stall, payload out_data with token_kind, token_length,
// error_code and last_of_run); last_of_run marks the final result of a byte.
// Lexer state updates in the cycle a byte is accepted; its results are
// written into a four-entry output queue, from whose head out_data is read.
// Throughput is one byte per cycle while the queue has room for two more
// results; the queue drain rate of one result per cycle while out_stall is
// low sets the limit when bytes produce two results back to back.
// in_stall rises when fewer than two queue slots are free, so a stalled
// receiver backs up into the sender without any loss.
// Reset clears all lexer state to root mode and empties the queue; no
// clearing pass is needed. After an end_of_text byte the lexer returns to
// its reset state by itself. After an error, bytes are dropped silently up
// to and including the end_of_text byte.
module grammar_notation_lexer_top #(
	parameter int unsigned MAX_NEST = gnl_pkg::MAX_NEST_DEF,
	parameter int unsigned LEN_BITS = gnl_pkg::LEN_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gnl_pkg::in_req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output gnl_pkg::out_req_t out_data
);

	localparam int unsigned DW = $clog2(MAX_NEST + 1);

	gnl_pkg::mode_t mode_q, mode_d;
	gnl_pkg::phase_t phase_q, phase_d;
	logic pend_q, pend_d, hold_q, hold_d;
	logic [DW-1:0] depth_q, depth_d;
	logic [LEN_BITS-1:0] len_q, len_d;
	logic [1:0] n_out;
	gnl_pkg::out_req_t res0, res1;

	// Output queue: four entries, read pointer, write pointer, fill count.
	gnl_pkg::out_req_t fifo_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic in_fire, out_fire;
	logic [1:0] push;

	gnl_step #(.MAX_NEST(MAX_NEST), .LEN_BITS(LEN_BITS)) u_step (
		.req(in_data), .mode_q(mode_q), .pend_q(pend_q), .phase_q(phase_q),
		.depth_q(depth_q), .len_q(len_q), .hold_q(hold_q),
		.mode_d(mode_d), .pend_d(pend_d), .phase_d(phase_d), .depth_d(depth_d),
		.len_d(len_d), .hold_d(hold_d), .n_out(n_out), .res0(res0), .res1(res1)
	);

	assign in_stall = cnt_q > 3'd2;
	assign in_fire = in_valid && !in_stall;
	assign out_valid = cnt_q != 3'd0;
	assign out_fire = out_valid && !out_stall;
	assign out_data = fifo_q[rd_q];
	assign push = in_fire ? n_out : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= gnl_pkg::MODE_ROOT;
			phase_q <= gnl_pkg::PH_IDLE;
			pend_q <= 1'b0;
			hold_q <= 1'b0;
			depth_q <= '0;
			len_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (in_fire) begin
				mode_q <= mode_d;
				phase_q <= phase_d;
				pend_q <= pend_d;
				hold_q <= hold_d;
				depth_q <= depth_d;
				len_q <= len_d;
			end
			wr_q <= wr_q + push;
			if (out_fire) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, push} - {2'b00, out_fire};
		end
	end

	always_ff @(posedge clk) begin
		if (push != 2'd0) fifo_q[wr_q] <= res0;
		if (push == 2'd2) fifo_q[wr_q + 1'b1] <= res1;
	end

`ifndef SYNTHESIS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("output queue overflow");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && n_out == 2'd2) |-> res1.last_of_run && !res0.last_of_run)
		else $error("last_of_run misplaced");
	a_hold_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && hold_q) |-> n_out == 2'd0)
		else $error("result while discarding");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == gnl_pkg::PH_IDLE) |-> depth_q == '0)
		else $error("comment depth left open");
`endif

endmodule

FILE: sim/tb_grammar_notation_lexer_top.sv
// Self-checking bench for the grammar notation lexer top level.
// Drives source bytes through the request channel and checks every result
// against a behavioral lexer held here. Depends on gnl_pkg and the RTL.
`timescale 1ns / 100ps

module tb_grammar_notation_lexer_top;

	localparam int unsigned NEST_LIMIT = 255;
	localparam int unsigned LEN_CAP = 16'hFFFF;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	gnl_pkg::in_req_t in_data;
	logic out_valid;
	logic out_stall;
	gnl_pkg::out_req_t out_data;

	grammar_notation_lexer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// Source bytes waiting to be offered, and the token results they should give.
	gnl_pkg::in_req_t byte_queue[$];
	gnl_pkg::out_req_t token_queue[$];

	int mismatch_count = 0;
	int bytes_sent = 0;
	bit stim_done = 0;
	bit hold_off = 0;      // request from the stimulus: receiver stalls long
	bit pause_send = 0;    // request from the stimulus: sender waits for drain

	// Lexer state mirrored by the bench.
	gnl_pkg::mode_t lx_mode;
	bit lx_look;
	gnl_pkg::phase_t lx_phase;
	int unsigned lx_depth;
	int unsigned lx_len;
	bit lx_err;
	gnl_pkg::out_req_t lx_res[$];

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[grammar_notation_lexer_top] ERROR");
		$finish;
	end

	function automatic bit sp_byte(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d || b == 8'h0b
			|| b == 8'h0c;
	endfunction

	function automatic bit letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit word_char(input logic [7:0] b);
		return letter(b) || (b >= "0" && b <= "9") || b == "_";
	endfunction

	task automatic lx_clear();
		lx_mode = gnl_pkg::MODE_ROOT;
		lx_look = 0;
		lx_phase = gnl_pkg::PH_IDLE;
		lx_depth = 0;
		lx_len = 0;
		lx_err = 0;
	endtask

	task automatic push_token(input logic [3:0] kind, input int unsigned len,
			input logic [2:0] code);
		gnl_pkg::out_req_t r;
		r.token_kind = kind;
		r.token_length = len[15:0];
		r.error_code = code;
		r.last_of_run = 0;
		lx_res.push_back(r);
	endtask

	task automatic raise_error(input logic [2:0] code);
		lx_err = 1;
		lx_phase = gnl_pkg::PH_IDLE;
		lx_len = 0;
		push_token(gnl_pkg::TK_HASHTAG, 0, code);
	endtask

	task automatic close_single(input logic [3:0] kind);
		lx_phase = gnl_pkg::PH_IDLE;
		lx_len = 0;
		push_token(kind, 1, gnl_pkg::ERR_NONE);
	endtask

	task automatic grow();
		if (lx_len < LEN_CAP)
			lx_len++;
	endtask

	// Starts a token from idle; adjacent means the byte just ended a hashtag.
	task automatic open_token(input logic [7:0] b, input bit adjacent);
		if (sp_byte(b) || b == "/") begin
			if (adjacent)
				lx_look = 1;
		end else begin
			if (lx_look || adjacent) begin
				if (b == "=")
					lx_mode = gnl_pkg::MODE_RULE;
				else if (adjacent && b == "(")
					lx_mode = gnl_pkg::MODE_FUNC;
			end
			lx_look = 0;
		end
		if (sp_byte(b)) begin
			close_single(gnl_pkg::TK_SPACE);
			return;
		end
		if (b == "/" || b == "#") begin
			lx_phase = (b == "/") ? gnl_pkg::PH_SLASH : gnl_pkg::PH_HASH1;
			lx_len = 1;
			return;
		end
		if (lx_mode == gnl_pkg::MODE_RULE) begin
			case (b)
				"'": begin lx_phase = gnl_pkg::PH_SQ; lx_len = 1; return; end
				"\"": begin lx_phase = gnl_pkg::PH_DQ; lx_len = 1; return; end
				",": begin close_single(gnl_pkg::TK_COMMA); return; end
				";": begin
					lx_mode = gnl_pkg::MODE_ROOT;
					close_single(gnl_pkg::TK_SEMI);
					return;
				end
				"|": begin close_single(gnl_pkg::TK_BAR); return; end
				"-": begin close_single(gnl_pkg::TK_MINUS); return; end
				"=": begin close_single(gnl_pkg::TK_EQUALS); return; end
				"(", ")": begin close_single(gnl_pkg::TK_PAREN); return; end
				"{", "}": begin close_single(gnl_pkg::TK_CURLY); return; end
				"[", "]": begin close_single(gnl_pkg::TK_SQUARE); return; end
				default: ;
			endcase
		end else if (lx_mode == gnl_pkg::MODE_FUNC && (b == "(" || b == ")")) begin
			close_single(gnl_pkg::TK_CALLPAREN);
			return;
		end
		raise_error(gnl_pkg::ERR_BYTE);
	endtask

	// Advances the mirrored lexer by one byte and queues its expected results.
	task automatic lex_byte(input gnl_pkg::in_req_t item);
		logic [7:0] b;
		bit eot;
		b = item.source_byte;
		eot = item.end_of_text;
		lx_res = {};
		if (lx_err) begin
			if (eot)
				lx_clear();
			return;
		end
		case (lx_phase)
			gnl_pkg::PH_HASH1: begin
				if (letter(b)) begin
					grow();
					lx_phase = gnl_pkg::PH_HASHID;
				end else
					raise_error(gnl_pkg::ERR_BYTE);
			end
			gnl_pkg::PH_HASHID: begin
				if (word_char(b))
					grow();
				else begin
					push_token(gnl_pkg::TK_HASHTAG, lx_len, gnl_pkg::ERR_NONE);
					lx_phase = gnl_pkg::PH_IDLE;
					lx_len = 0;
					open_token(b, 1);
				end
			end
			gnl_pkg::PH_SLASH: begin
				if (b == "/") begin
					grow();
					lx_phase = gnl_pkg::PH_LINE;
				end else if (b == "{") begin
					grow();
					lx_depth = 1;
					lx_phase = gnl_pkg::PH_BLOCK;
				end else
					raise_error(gnl_pkg::ERR_BYTE);
			end
			gnl_pkg::PH_LINE: begin
				grow();
				if (b == 8'h0a) begin
					push_token(gnl_pkg::TK_COMMENT, lx_len, gnl_pkg::ERR_NONE);
					lx_phase = gnl_pkg::PH_IDLE;
					lx_len = 0;
				end
			end
			gnl_pkg::PH_SQ, gnl_pkg::PH_DQ: begin
				grow();
				if (b == ((lx_phase == gnl_pkg::PH_SQ) ? "'" : "\"")) begin
					push_token((lx_phase == gnl_pkg::PH_SQ) ? gnl_pkg::TK_SQSTR
						: gnl_pkg::TK_DQSTR, lx_len, gnl_pkg::ERR_NONE);
					lx_phase = gnl_pkg::PH_IDLE;
					lx_len = 0;
				end
			end
			gnl_pkg::PH_BLOCK, gnl_pkg::PH_BSLASH, gnl_pkg::PH_BBRACE: begin
				grow();
				if (lx_phase == gnl_pkg::PH_BSLASH && b == "{") begin
					if (lx_depth >= NEST_LIMIT)
						raise_error(gnl_pkg::ERR_NEST);
					else begin
						lx_depth++;
						lx_phase = gnl_pkg::PH_BLOCK;
					end
				end else if (lx_phase == gnl_pkg::PH_BBRACE && b == "/") begin
					if (lx_depth > 0)
						lx_depth--;
					if (lx_depth == 0) begin
						push_token(gnl_pkg::TK_COMMENT, lx_len, gnl_pkg::ERR_NONE);
						lx_phase = gnl_pkg::PH_IDLE;
						lx_len = 0;
					end else
						lx_phase = gnl_pkg::PH_BLOCK;
				end else if (b == "/")
					lx_phase = gnl_pkg::PH_BSLASH;
				else if (b == "}")
					lx_phase = gnl_pkg::PH_BBRACE;
				else
					lx_phase = gnl_pkg::PH_BLOCK;
			end
			default: open_token(b, 0);
		endcase
		if (eot && !lx_err) begin
			case (lx_phase)
				gnl_pkg::PH_HASH1, gnl_pkg::PH_SLASH: raise_error(gnl_pkg::ERR_BYTE);
				gnl_pkg::PH_HASHID:
					push_token(gnl_pkg::TK_HASHTAG, lx_len, gnl_pkg::ERR_NONE);
				gnl_pkg::PH_LINE:
					push_token(gnl_pkg::TK_COMMENT, lx_len, gnl_pkg::ERR_NONE);
				gnl_pkg::PH_SQ: raise_error(gnl_pkg::ERR_SQ);
				gnl_pkg::PH_DQ: raise_error(gnl_pkg::ERR_DQ);
				gnl_pkg::PH_BLOCK, gnl_pkg::PH_BSLASH, gnl_pkg::PH_BBRACE:
					raise_error(gnl_pkg::ERR_COMMENT);
				default: ;
			endcase
		end
		if (eot)
			lx_clear();
		if (lx_res.size() > 0)
			lx_res[lx_res.size() - 1].last_of_run = 1;
	endtask

	// Stimulus helpers: append a string, optionally closing the text.
	task automatic add_text(input string s, input bit close_text);
		gnl_pkg::in_req_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.source_byte = s[i];
			it.end_of_text = close_text && (i == s.len() - 1);
			byte_queue.push_back(it);
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input bit eot);
		gnl_pkg::in_req_t it;
		it.source_byte = b;
		it.end_of_text = eot;
		byte_queue.push_back(it);
	endtask

	function automatic string rand_ident(input int n);
		string s;
		string pool;
		pool = "abcXYZqrs_09Tm";
		s = "";
		s = {s, string'(8'(letter(pool[0]) ? "k" : "k"))};
		for (int i = 0; i < n; i++)
			s = {s, string'(pool[$urandom_range(pool.len() - 1)])};
		return s;
	endfunction

	// One well-formed piece (rule, call, comment or spacing), with random content.
	function automatic string rand_piece();
		string s;
		case ($urandom_range(7))
			0: s = {"#", rand_ident($urandom_range(4)), " = ", "'a b'", " | ",
				"#", rand_ident(2), ",", "\"q\"", " -[x]{y}(z);\n"};
			1: s = {"#", rand_ident($urandom_range(6)), "(#", rand_ident(1), ")\t"};
			2: s = {"// note ", rand_ident(3), "\n"};
			3: s = {"/{ outer /{ in }/ x }/ "};
			4: s = {"#", rand_ident(2), " /{c}/ =#", rand_ident(1), ";"};
			5: s = {"#", rand_ident(1), "=\"", rand_ident(3), "\";\r\n"};
			6: s = {" \v\f#", rand_ident(3), " "};
			default: s = {"#", rand_ident(2), "='", rand_ident(2), "'|-;"};
		endcase
		return s;
	endfunction

	// Driver: offers bytes from the queue with random gaps.
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
			gap_left <= 0;
			lx_clear();
		end else begin
			if (in_valid && !in_stall) begin
				lex_byte(in_data);
				foreach (lx_res[i])
					token_queue.push_back(lx_res[i]);
				bytes_sent <= bytes_sent + 1;
				void'(byte_queue.pop_front());
			end
			// A new request is raised only after the previous one is accepted.
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0 || byte_queue.size() == 0 ||
						(pause_send && token_queue.size() > 0)) begin
					in_valid <= 0;
					if (gap_left > 0)
						gap_left <= gap_left - 1;
				end else begin
					if (in_valid && !in_stall) begin
						// Current request accepted; draw a gap before the next one.
						automatic int g = $urandom_range(4);
						if (g != 0 && $urandom_range(3) != 0) begin
							in_valid <= 0;
							gap_left <= g - 1;
						end else begin
							in_valid <= 1;
							in_data <= byte_queue[0];
						end
					end else begin
						in_valid <= 1;
						in_data <= byte_queue[0];
					end
				end
			end
		end
	end

	// Monitor: checks each accepted result and draws receiver stalls.
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			stall_left <= 0;
		end else begin
			automatic int nxt = stall_left;
			if (out_valid && !out_stall) begin
				if (token_queue.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result kind=%0d len=%0d err=%0d last=%0b",
							out_data.token_kind, out_data.token_length,
							out_data.error_code, out_data.last_of_run);
				end else begin
					automatic gnl_pkg::out_req_t want = token_queue.pop_front();
					if (want !== out_data) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
								want.token_kind, want.token_length, want.error_code,
								want.last_of_run, out_data.token_kind,
								out_data.token_length, out_data.error_code,
								out_data.last_of_run);
					end
				end
				nxt = $urandom_range(4);
			end
			if (hold_off)
				out_stall <= 1;
			else if (nxt > 0 && $urandom_range(2) != 0) begin
				out_stall <= 1;
				nxt = nxt - 1;
			end else
				out_stall <= 0;
			stall_left <= nxt;
		end
	end

	// Long receiver hold-off while the sender keeps offering bytes.
	initial begin
		@(posedge arst_n);
		repeat (400) @(posedge clk);
		hold_off = 1;
		repeat (60) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		string s;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n = 1;

		// Directed: every token kind, both modes switches, the lone slash and
		// hash errors, each unclosed construct, nesting, and discard after error.
		add_text("#rule = 'a' \"b\" , | - ( ) { } [ ] ;", 1);
		add_text("#f(#g)", 1);
		add_text("#h /{ x }/ = #k;", 1);
		add_text("// line\n#t", 1);
		add_text("/{ a /{ b }/ c }/", 1);
		add_text("#r='open", 1);
		add_text("#r=\"open", 1);
		add_text("/{ open", 1);
		add_text("/x junk", 1);
		add_text("#9", 1);
		add_text("@", 1);
		add_text("#", 1);
		add_text("/", 1);
		add_byte(8'hFF, 0);
		add_byte(8'h00, 1);
		add_text("//eot", 1);
		// Nesting overflow: one more opener than the depth allows.
		s = "";
		for (int i = 0; i <= NEST_LIMIT; i++)
			s = {s, "/{"};
		add_text(s, 1);

		// Random: mostly well-formed texts, some noise drawn from the full byte range.
		while (byte_queue.size() + bytes_sent < 950) begin
			if ($urandom_range(9) < 7) begin
				s = "";
				repeat ($urandom_range(1, 4))
					s = {s, rand_piece()};
				add_text(s, $urandom_range(5) != 0);
			end else begin
				repeat ($urandom_range(1, 6))
					add_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
			end
			if (byte_queue.size() > 200)
				@(posedge clk);
		end
		add_text("#end", 1);

		// Sender pause until everything expected has drained.
		pause_send = 1;
		while (token_queue.size() > 0)
			@(posedge clk);
		pause_send = 0;
		add_text("#after = 'x';", 1);

		while (byte_queue.size() > 0 || in_valid || token_queue.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && token_queue.size() == 0)
			$display("[grammar_notation_lexer_top] OK");
		else
			$display("[grammar_notation_lexer_top] ERROR");
		$finish;
	end

endmodule

FILE: grammar_notation_lexer_top.f
rtl/core/gnl_pkg.sv
rtl/core/gnl_step.sv
rtl/core/grammar_notation_lexer_top.sv
sim/tb_grammar_notation_lexer_top.sv
